>>> src/pwsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwsm_pkg
// Shared types and constants of the projective warp source mapper.
// ----------------------------------------------------------------------------
package pwsm_pkg;

  // fixed-point formats
  localparam int COEF_W        = 21;  // signed Q5.15 coefficient
  localparam int ORG_W         = 24;  // signed Q15.8 origin
  localparam int ORG_FRAC_BITS = 8;   // homogeneous 1.0 is 1 << 8
  localparam int PIX_W         = 12;
  localparam int SIZE_W        = 13;
  localparam int ROW_W         = 63;
  localparam int XY_W          = 25;  // (pixel << 8) + origin
  localparam int PROD_W        = 46;  // coefficient times x or y
  localparam int DOT_W         = 48;  // row dot product
  localparam int Q_W           = 14;  // quotient floor(2p / w)
  localparam int DIV_STEPS     = 14;
  localparam int REM_W         = 62;  // holds w << 13 and 2p

  localparam logic [SIZE_W-1:0] MAX_DIM = 13'd4096;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // register indexes
  localparam int ADDR_W = 6;
  localparam logic [2:0] REG_INV_ROW0   = 3'd0;
  localparam logic [2:0] REG_INV_ROW1   = 3'd1;
  localparam logic [2:0] REG_INV_ROW2   = 3'd2;
  localparam logic [2:0] REG_SRC_WIDTH  = 3'd3;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd4;
  localparam logic [2:0] REG_ORIGIN_X   = 3'd5;
  localparam logic [2:0] REG_ORIGIN_Y   = 3'd6;

  // configuration seen by front and back
  typedef struct packed {
    logic [ROW_W-1:0]  inv_row0;
    logic [ROW_W-1:0]  inv_row1;
    logic [ROW_W-1:0]  inv_row2;
    logic [SIZE_W-1:0] src_width;
    logic [SIZE_W-1:0] src_height;
    logic [ORG_W-1:0]  origin_x;
    logic [ORG_W-1:0]  origin_y;
  } warp_cfg_t;

  // sign-normalized dot products, w >= 0
  typedef struct packed {
    logic [DOT_W-1:0] p_u;
    logic [DOT_W-1:0] p_v;
    logic [DOT_W-1:0] w;
  } dot_item_t;

endpackage
`default_nettype wire

>>> src/pwsm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwsm_front
// Forms x, y, multiplies by the inverse matrix and normalizes the divisor sign.
// ----------------------------------------------------------------------------
module pwsm_front import pwsm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire warp_cfg_t        cfg,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [PIX_W-1:0] in_col,
  input  wire logic [PIX_W-1:0] in_row,
  input  wire logic             q_full,
  output logic                  q_push,
  output dot_item_t             q_item
);

  logic                     adv;
  logic                     v1, v2, v3, v4;
  logic signed [XY_W-1:0]   x1, y1;
  logic signed [PROD_W-1:0] pa [0:2];
  logic signed [PROD_W-1:0] pb [0:2];
  logic signed [COEF_W-1:0] pc [0:2];
  logic signed [DOT_W-1:0]  dot [0:2];
  logic signed [COEF_W-1:0] ca [0:2];
  logic signed [COEF_W-1:0] cb [0:2];
  logic signed [COEF_W-1:0] cc [0:2];
  logic signed [DOT_W-1:0]  sum [0:2];
  dot_item_t                item4;

  // whole front holds while its last word waits on a full queue
  assign adv      = !v4 || !q_full;
  assign in_ready = adv;
  assign q_push   = v4 && !q_full;
  assign q_item   = item4;

  // coefficient unpacking
  always_comb begin
    ca[0] = $signed(cfg.inv_row0[20:0]);
    cb[0] = $signed(cfg.inv_row0[41:21]);
    cc[0] = $signed(cfg.inv_row0[62:42]);
    ca[1] = $signed(cfg.inv_row1[20:0]);
    cb[1] = $signed(cfg.inv_row1[41:21]);
    cc[1] = $signed(cfg.inv_row1[62:42]);
    ca[2] = $signed(cfg.inv_row2[20:0]);
    cb[2] = $signed(cfg.inv_row2[41:21]);
    cc[2] = $signed(cfg.inv_row2[62:42]);
  end

  // row sums, constant term scaled by 1.0
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = {{(DOT_W-PROD_W){pa[r][PROD_W-1]}}, pa[r]}
             + {{(DOT_W-PROD_W){pb[r][PROD_W-1]}}, pb[r]}
             + {{(DOT_W-COEF_W-ORG_FRAC_BITS){pc[r][COEF_W-1]}}, pc[r],
                {ORG_FRAC_BITS{1'b0}}};
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (adv) begin
      x1 <= $signed({{(XY_W-PIX_W-ORG_FRAC_BITS){1'b0}}, in_col, {ORG_FRAC_BITS{1'b0}}})
          + $signed({cfg.origin_x[ORG_W-1], cfg.origin_x});
      y1 <= $signed({{(XY_W-PIX_W-ORG_FRAC_BITS){1'b0}}, in_row, {ORG_FRAC_BITS{1'b0}}})
          + $signed({cfg.origin_y[ORG_W-1], cfg.origin_y});
      for (int r = 0; r < 3; r++) begin
        pa[r]  <= PROD_W'(ca[r] * x1);
        pb[r]  <= PROD_W'(cb[r] * y1);
        pc[r]  <= cc[r];
        dot[r] <= sum[r];
      end
      if (dot[2][DOT_W-1]) begin
        item4.p_u <= DOT_W'(-dot[0]);
        item4.p_v <= DOT_W'(-dot[1]);
        item4.w   <= DOT_W'(-dot[2]);
      end else begin
        item4.p_u <= dot[0];
        item4.p_v <= dot[1];
        item4.w   <= dot[2];
      end
    end
  end

endmodule
`default_nettype wire

>>> src/pwsm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwsm_queue
// Short first-in first-out queue of dot-product words between front and back.
// ----------------------------------------------------------------------------
module pwsm_queue import pwsm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire dot_item_t push_item,
  input  wire logic      pop,
  output dot_item_t      head,
  output logic           empty,
  output logic           full
);

  dot_item_t         mem [0:QDEPTH-1];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QDEPTH));
  assign head  = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule
`default_nettype wire

>>> src/pwsm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwsm_back
// Range check, pipelined restoring division, rounding and clamping.
// ----------------------------------------------------------------------------
module pwsm_back import pwsm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire warp_cfg_t   cfg,
  input  wire dot_item_t   head,
  input  wire logic        q_empty,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [PIX_W-1:0] out_col,
  output logic [PIX_W-1:0] out_row,
  output logic             out_inside
);

  logic                 adv;
  logic                 dv [0:DIV_STEPS];
  logic [REM_W-1:0]     ru [0:DIV_STEPS];
  logic [REM_W-1:0]     rv [0:DIV_STEPS];
  logic [Q_W-1:0]       qu [0:DIV_STEPS];
  logic [Q_W-1:0]       qv [0:DIV_STEPS];
  logic                 oku [0:DIV_STEPS];
  logic                 okv [0:DIV_STEPS];
  logic [DOT_W-1:0]     wd [0:DIV_STEPS];
  logic [REM_W:0]       tu [0:DIV_STEPS-1];
  logic [REM_W:0]       tv [0:DIV_STEPS-1];
  logic [REM_W-1:0]     wsh [0:DIV_STEPS-1];
  logic [REM_W-1:0]     w_top;
  logic                 ok_u0, ok_v0;
  logic [SIZE_W-1:0]    lim_w, lim_h;
  logic [Q_W-1:0]       tq_u, tq_v;
  logic [SIZE_W-1:0]    rc, rr;
  logic                 in_c, in_r;

  // whole back moves when the output register is free or taken
  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && !q_empty;

  // range check at entry: 0 <= p < w << 13, w nonzero
  assign w_top = REM_W'(head.w) << (DIV_STEPS - 1);
  assign ok_u0 = !head.p_u[DOT_W-1] && (head.w != '0) && (REM_W'(head.p_u) < w_top);
  assign ok_v0 = !head.p_v[DOT_W-1] && (head.w != '0) && (REM_W'(head.p_v) < w_top);

  // trial subtraction per quotient bit, most significant first
  always_comb begin
    for (int s = 0; s < DIV_STEPS; s++) begin
      wsh[s] = REM_W'(wd[s]) << (DIV_STEPS - 1 - s);
      tu[s]  = {1'b0, ru[s]} - {1'b0, wsh[s]};
      tv[s]  = {1'b0, rv[s]} - {1'b0, wsh[s]};
    end
  end

  // size limits and rounding half up: r = (floor(2p/w) + 1) / 2
  always_comb begin
    lim_w = (cfg.src_width > MAX_DIM) ? MAX_DIM : cfg.src_width;
    lim_h = (cfg.src_height > MAX_DIM) ? MAX_DIM : cfg.src_height;
    tq_u  = qu[DIV_STEPS];
    tq_v  = qv[DIV_STEPS];
    in_c  = oku[DIV_STEPS] && (lim_w != '0) && (tq_u < {lim_w, 1'b0});
    in_r  = okv[DIV_STEPS] && (lim_h != '0) && (tq_v < {lim_h, 1'b0});
    rc    = SIZE_W'((tq_u + 1'b1) >> 1);
    rr    = SIZE_W'((tq_v + 1'b1) >> 1);
    if (rc > lim_w - 1'b1) rc = lim_w - 1'b1;
    if (rr > lim_h - 1'b1) rr = lim_h - 1'b1;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= DIV_STEPS; s++) dv[s] <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      dv[0] <= q_pop;
      for (int s = 0; s < DIV_STEPS; s++) dv[s+1] <= dv[s];
      out_valid <= dv[DIV_STEPS];
    end
  end

  // divider stages and output register
  always_ff @(posedge clk) begin
    if (adv) begin
      ru[0]  <= REM_W'({head.p_u, 1'b0});
      rv[0]  <= REM_W'({head.p_v, 1'b0});
      qu[0]  <= '0;
      qv[0]  <= '0;
      oku[0] <= ok_u0;
      okv[0] <= ok_v0;
      wd[0]  <= head.w;
      for (int s = 0; s < DIV_STEPS; s++) begin
        ru[s+1]  <= tu[s][REM_W] ? ru[s] : tu[s][REM_W-1:0];
        rv[s+1]  <= tv[s][REM_W] ? rv[s] : tv[s][REM_W-1:0];
        qu[s+1]  <= {qu[s][Q_W-2:0], !tu[s][REM_W]};
        qv[s+1]  <= {qv[s][Q_W-2:0], !tv[s][REM_W]};
        oku[s+1] <= oku[s];
        okv[s+1] <= okv[s];
        wd[s+1]  <= wd[s];
      end
      out_inside <= in_c && in_r;
      out_col    <= (in_c && in_r) ? rc[PIX_W-1:0] : '0;
      out_row    <= (in_c && in_r) ? rr[PIX_W-1:0] : '0;
    end
  end

endmodule
`default_nettype wire

>>> src/projective_warp_source_mapper_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// projective_warp_source_mapper_unit
// Maps an output pixel to its nearest source pixel through an inverse warp.
// ----------------------------------------------------------------------------
// One coordinate word is taken per clock and one result word leaves per clock while the output side accepts words.
// From input to output a word passes the front stages (origin add, multiply,
// row sum, sign normalize), the 4-word queue, and the back: an entry register,
// the 14-step restoring divider pipeline (one quotient bit per stage) and an
// output register.
// The queue lets the front keep taking words while the output side stalls, until the queue is full.
// Registers sit at byte address 8*i on a 64-bit port; write only while idle.
// There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module projective_warp_source_mapper_unit import pwsm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  // input coordinate
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [23:0]       s_tdata,   // out_col[11:0], out_row[23:12]
  // source pixel result
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [23:0]            m_tdata,   // src_col[11:0], src_row[23:12]
  output logic                   m_tuser,   // inside_res
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [63:0]       pwdata,
  output logic [63:0]            prdata,
  output logic                   pready
);

  warp_cfg_t        cfg;
  logic [2:0]       reg_idx;
  logic             cfg_wr;
  logic             q_full, q_empty, q_push, q_pop;
  dot_item_t        q_in, q_head;
  logic [PIX_W-1:0] src_col, src_row;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite;
  assign m_tdata = {src_row, src_col};

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inv_row0   <= '0;
      cfg.inv_row1   <= '0;
      cfg.inv_row2   <= '0;
      cfg.src_width  <= MAX_DIM;
      cfg.src_height <= MAX_DIM;
      cfg.origin_x   <= '0;
      cfg.origin_y   <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_INV_ROW0:   cfg.inv_row0   <= pwdata[ROW_W-1:0];
        REG_INV_ROW1:   cfg.inv_row1   <= pwdata[ROW_W-1:0];
        REG_INV_ROW2:   cfg.inv_row2   <= pwdata[ROW_W-1:0];
        REG_SRC_WIDTH:  cfg.src_width  <= pwdata[SIZE_W-1:0];
        REG_SRC_HEIGHT: cfg.src_height <= pwdata[SIZE_W-1:0];
        REG_ORIGIN_X:   cfg.origin_x   <= pwdata[ORG_W-1:0];
        REG_ORIGIN_Y:   cfg.origin_y   <= pwdata[ORG_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      REG_INV_ROW0:   prdata = 64'(cfg.inv_row0);
      REG_INV_ROW1:   prdata = 64'(cfg.inv_row1);
      REG_INV_ROW2:   prdata = 64'(cfg.inv_row2);
      REG_SRC_WIDTH:  prdata = 64'(cfg.src_width);
      REG_SRC_HEIGHT: prdata = 64'(cfg.src_height);
      REG_ORIGIN_X:   prdata = 64'(cfg.origin_x);
      REG_ORIGIN_Y:   prdata = 64'(cfg.origin_y);
      default:        prdata = '0;
    endcase
  end

  // front: coordinate to dot products
  pwsm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_col   (s_tdata[11:0]),
    .in_row   (s_tdata[23:12]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  // queue between the halves
  pwsm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // back: division, range test, rounding
  pwsm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_col    (src_col),
    .out_row    (src_row),
    .out_inside (m_tuser)
  );

  // an outside pixel carries zero coordinates
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("outside pixel with nonzero coordinates");

  // an inside pixel lies within the source image
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (13'(src_col) < cfg.src_width) && (13'(src_row) < cfg.src_height))
    else $error("inside pixel beyond source image");

  // never push into a full queue
  assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("queue overflow");

  // never pop an empty queue
  assert property (@(posedge clk) disable iff (rst)
    q_empty |-> !q_pop)
    else $error("queue underflow");

endmodule
`default_nettype wire

>>> dv/pwsm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsm_checker
// Watches the register port and both streams of the warp source mapper,
// predicts each source pixel from the observed configuration and compares.
// ----------------------------------------------------------------------------
module pwsm_checker import pwsm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  input  wire logic              s_tready,
  input  wire logic [23:0]       s_tdata,
  input  wire logic              m_tvalid,
  input  wire logic              m_tready,
  input  wire logic [23:0]       m_tdata,
  input  wire logic              m_tuser,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [63:0]       pwdata,
  input  wire logic              pready,
  output int                     mismatches,
  output int                     words_pending
);

  typedef struct packed {
    logic             in_img;
    logic [PIX_W-1:0] row;
    logic [PIX_W-1:0] col;
  } src_pix_t;

  warp_cfg_t cfg;
  src_pix_t  pix_q[$];

  // one row of the inverse matrix times (x, y, 1)
  function automatic longint row_dot(logic [ROW_W-1:0] r, longint x, longint y);
    logic signed [COEF_W-1:0] a, b, c;
    a = r[20:0];
    b = r[41:21];
    c = r[62:42];
    return longint'(a) * x + longint'(b) * y + longint'(c) * (longint'(1) << ORG_FRAC_BITS);
  endfunction

  // inside test and round half up on one axis, w > 0
  function automatic bit fit_axis(longint p, longint w, logic [SIZE_W-1:0] size,
                                  output logic [PIX_W-1:0] idx);
    longint lim, r;
    lim = (size > MAX_DIM) ? longint'(MAX_DIM) : longint'(size);
    idx = '0;
    if (lim == 0 || p < 0 || p >= lim * w) return 1'b0;
    r = (2 * p + w) / (2 * w);
    if (r > lim - 1) r = lim - 1;
    idx = r[PIX_W-1:0];
    return 1'b1;
  endfunction

  function automatic src_pix_t map_source(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
    longint   x, y, u, v, w;
    bit       cin, rin;
    src_pix_t res;
    x = longint'({col, 8'h00}) + longint'(signed'(cfg.origin_x));
    y = longint'({row, 8'h00}) + longint'(signed'(cfg.origin_y));
    u = row_dot(cfg.inv_row0, x, y);
    v = row_dot(cfg.inv_row1, x, y);
    w = row_dot(cfg.inv_row2, x, y);
    res = '0;
    if (w < 0) begin
      u = -u;
      v = -v;
      w = -w;
    end
    if (w != 0) begin
      cin = fit_axis(u, w, cfg.src_width, res.col);
      rin = fit_axis(v, w, cfg.src_height, res.row);
      res.in_img = cin && rin;
    end
    if (!res.in_img) res = '0;
    return res;
  endfunction

  // config snoop, prediction on input words, compare on output words
  always @(posedge clk) begin
    src_pix_t exp_pix;
    if (rst) begin
      cfg <= '{default: '0, src_width: MAX_DIM, src_height: MAX_DIM};
      mismatches <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_INV_ROW0:   cfg.inv_row0 <= pwdata[ROW_W-1:0];
          REG_INV_ROW1:   cfg.inv_row1 <= pwdata[ROW_W-1:0];
          REG_INV_ROW2:   cfg.inv_row2 <= pwdata[ROW_W-1:0];
          REG_SRC_WIDTH:  cfg.src_width <= pwdata[SIZE_W-1:0];
          REG_SRC_HEIGHT: cfg.src_height <= pwdata[SIZE_W-1:0];
          REG_ORIGIN_X:   cfg.origin_x <= pwdata[ORG_W-1:0];
          REG_ORIGIN_Y:   cfg.origin_y <= pwdata[ORG_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) pix_q.push_back(map_source(s_tdata[11:0], s_tdata[23:12]));
      if (m_tvalid && m_tready) begin
        if (pix_q.size() == 0) begin
          $error("unexpected result word: src_col %0d src_row %0d inside_res %0d",
                 m_tdata[11:0], m_tdata[23:12], m_tuser);
          mismatches <= mismatches + 1;
        end else begin
          exp_pix = pix_q.pop_front();
          if (exp_pix.col !== m_tdata[11:0] || exp_pix.row !== m_tdata[23:12] ||
              exp_pix.in_img !== m_tuser) begin
            if (exp_pix.col !== m_tdata[11:0])
              $error("src_col: expected %0d, actual %0d", exp_pix.col, m_tdata[11:0]);
            if (exp_pix.row !== m_tdata[23:12])
              $error("src_row: expected %0d, actual %0d", exp_pix.row, m_tdata[23:12]);
            if (exp_pix.in_img !== m_tuser)
              $error("inside_res: expected %0d, actual %0d", exp_pix.in_img, m_tuser);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

  always @* words_pending = pix_q.size();

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives coordinate words and register writes into the warp source mapper
// under random idling on both streams; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import pwsm_pkg::*;

  localparam logic [2:0] REG_UNMAPPED = 3'd7;  // no register behind this index
  localparam int DRAIN_CYCLES = 30;
  localparam int LONG_STALL = 200;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [23:0]       s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [23:0]       m_tdata;
  logic              m_tuser;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [63:0]       pwdata = '0;
  logic [63:0]       prdata;
  logic              pready;
  int                mismatches, words_pending;
  int                stall_req = 0, stall_done = 0;
  bit                no_gaps = 1'b0;

  projective_warp_source_mapper_unit DUT (.*);

  pwsm_checker u_checker (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("** projective_warp_source_mapper_unit: FAILED **");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random backpressure plus requested long hold-offs
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (stall_req != stall_done) begin
        m_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        stall_done++;
      end else begin
        n = idle_len();
        m_tready <= (n == 0);
        if (n > 0) repeat (n - 1) @(posedge clk);
      end
    end
  end

  function automatic logic [ROW_W-1:0] coefs(int a, int b, int c);
    return {c[COEF_W-1:0], b[COEF_W-1:0], a[COEF_W-1:0]};
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_warp(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1,
                           logic [ROW_W-1:0] r2, logic [SIZE_W-1:0] wid,
                           logic [SIZE_W-1:0] hgt, int ox, int oy);
    reg_write(REG_INV_ROW0, 64'(r0));
    reg_write(REG_INV_ROW1, 64'(r1));
    reg_write(REG_INV_ROW2, 64'(r2));
    reg_write(REG_SRC_WIDTH, 64'(wid));
    reg_write(REG_SRC_HEIGHT, 64'(hgt));
    reg_write(REG_ORIGIN_X, 64'(ox[ORG_W-1:0]));
    reg_write(REG_ORIGIN_Y, 64'(oy[ORG_W-1:0]));
  endtask

  // one coordinate word; valid stays high across back-to-back words
  task automatic send_pixel(logic [11:0] col, logic [11:0] row);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {row, col};
    do @(posedge clk); while (!s_tready);
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic corner_pixels();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
  endtask

  // random matrix: mostly near-identity with mild perspective, some raw bits
  task automatic random_warp();
    int ox, oy;
    ox = $urandom_range(0, 16777215) - 8388608;
    oy = $urandom_range(0, 16777215) - 8388608;
    if ($urandom_range(0, 3) == 0) begin
      load_warp(ROW_W'({$urandom, $urandom}), ROW_W'({$urandom, $urandom}),
                ROW_W'({$urandom, $urandom}),
                13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)), ox, oy);
    end else begin
      ox = $urandom_range(0, 1048575) - 524288;
      oy = $urandom_range(0, 1048575) - 524288;
      load_warp(coefs(32768 + $urandom_range(0, 16383) - 8192,
                      $urandom_range(0, 8191) - 4096,
                      $urandom_range(0, 2097151) - 1048576),
                coefs($urandom_range(0, 8191) - 4096,
                      32768 + $urandom_range(0, 16383) - 8192,
                      $urandom_range(0, 2097151) - 1048576),
                coefs($urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8,
                      ($urandom_range(0, 1) ? 32768 : -32768) + $urandom_range(0, 2047) - 1024),
                13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)), ox, oy);
    end
  endtask

  initial begin
    logic [ROW_W-1:0] ident0, ident1, ident2;
    ident0 = coefs(32768, 0, 0);
    ident1 = coefs(0, 32768, 0);
    ident2 = coefs(0, 0, 32768);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: zero matrix, every divisor zero
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    drain();

    // identity, full size
    load_warp(ident0, ident1, ident2, 13'd4096, 13'd4096, 0, 0);
    corner_pixels();
    drain();

    // half-pixel origin: round half up and clamp to the last column
    load_warp(ident0, ident1, ident2, 13'd100, 13'd1, -128, 0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd100, 12'd0);
    send_pixel(12'd101, 12'd0);
    drain();

    // negative divisor, oversized image
    load_warp(coefs(-32768, 0, 0), coefs(0, -32768, 0), coefs(0, 0, -32768),
              13'd8191, 13'd8191, 8388607, -8388608);
    corner_pixels();
    drain();

    // zero size, then a write to an unmapped index that must change nothing
    load_warp(ident0, ident1, ident2, 13'd0, 13'd4096, 0, 0);
    reg_write(REG_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_pixel(12'd5, 12'd5);
    drain();

    // extreme coefficients
    load_warp(coefs(1048575, 1048575, 1048575), coefs(-1048576, -1048576, -1048576),
              coefs(1048575, -1048576, 1), 13'd1, 13'd4096, -8388608, 8388607);
    corner_pixels();
    drain();

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      no_gaps = (ph % 3 == 1);
      random_warp();
      for (int i = 0; i < 80; i++) begin
        if (ph == 2 && i == 20) stall_req++;
        if (ph == 5 && i == 40) drain();
        send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      end
      drain();
    end

    if (mismatches == 0 && words_pending == 0) begin
      $display("** projective_warp_source_mapper_unit: PASSED **");
    end else begin
      $display("** projective_warp_source_mapper_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/pwsm_pkg.sv
src/pwsm_front.sv
src/pwsm_queue.sv
src/pwsm_back.sv
src/projective_warp_source_mapper_unit.sv
dv/pwsm_checker.sv
dv/tb_top.sv
